// ===== rtl/mta_pkg.sv =====
// Shared types and constants for the mesh tangent accumulator.
// No dependencies.
package mta_pkg;

	localparam int IDX_W            = 10;
	localparam int POS_W            = 32;
	localparam int UV_W             = 16;
	localparam int SUM_W            = 48;
	localparam int CNT_W            = 16;
	localparam int OUT_W            = 32;
	localparam int DEF_VERTEX_DEPTH = 1024;

	// divider: 34-bit divisor, 48 quotient bits
	localparam int DIV_W = 34;
	localparam int QUO_W = 48;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TRI  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] rem_init;
		logic [QUO_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== rtl/mesh_tangent_accumulator_top.sv =====
// Mesh tangent accumulator, top level: request sequencer, vertex and sum memories,
// shared multiplier. Depends on mta_pkg and mta_div.
//
// Usage: one input channel (in_valid/in_ready) carries requests of three kinds:
// load vertex, add triangle, read averaged tangent. Only reads produce a result,
// on the output channel (out_valid/out_ready) held in a one-deep output register.
// Request handling:
//   load      : written at the accepting edge
//   triangle  : three passes through the shared one-bit-per-cycle divider, one
//               per tangent component; none when the UV determinant is zero,
//               and a component that saturates skips its pass.
//   read      : same divider, three passes by the share count; no pass for
//               an unused or out-of-range vertex.
// in_ready is high only while the sequencer is idle; one request at a time.
// A finished result waits in the output register while new requests are taken;
// a read that finishes while that register is still full waits for out_ready.
// Reset clears the sequencer and the output valid. Vertex memories are not
// cleared: a vertex must be loaded before a triangle or read refers to it.
module mesh_tangent_accumulator_top import mta_pkg::*; #(
	parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              kind,
	input  logic [IDX_W-1:0]        vertex_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [UV_W-1:0]  tex_u,
	input  logic signed [UV_W-1:0]  tex_v,
	input  logic [IDX_W-1:0]        corner_a,
	input  logic [IDX_W-1:0]        corner_b,
	input  logic [IDX_W-1:0]        corner_c,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] tangent_x,
	output logic signed [OUT_W-1:0] tangent_y,
	output logic signed [OUT_W-1:0] tangent_z,
	output logic                    unused_vertex,
	output logic                    clipped
);
	localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int PW = 3*POS_W + 2*UV_W;
	localparam int SW = 3*SUM_W + CNT_W;
	localparam int EW = POS_W + 1;
	localparam int DW = UV_W + 1;
	localparam int MW = EW + DW;
	localparam int AC = MW + 1;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_TRA  = 15'b000000000000010,
		S_TRB  = 15'b000000000000100,
		S_TRC  = 15'b000000000001000,
		S_TDIF = 15'b000000000010000,
		S_TMUL = 15'b000000000100000,
		S_TDST = 15'b000000001000000,
		S_TDWT = 15'b000000010000000,
		S_TAR  = 15'b000000100000000,
		S_TAW  = 15'b000001000000000,
		S_RRD  = 15'b000010000000000,
		S_RCHK = 15'b000100000000000,
		S_RDST = 15'b001000000000000,
		S_RDWT = 15'b010000000000000,
		S_ROUT = 15'b100000000000000
	} state_t;

	function automatic logic in_range(input logic [IDX_W-1:0] i);
		return 32'(i) < 32'(VERTEX_DEPTH);
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[AW-1:0];
	endfunction

	function automatic logic signed [EW-1:0] dpos(input logic [POS_W-1:0] p,
			input logic [POS_W-1:0] q);
		return $signed({p[POS_W-1], p}) - $signed({q[POS_W-1], q});
	endfunction

	function automatic logic signed [DW-1:0] duv(input logic [UV_W-1:0] p,
			input logic [UV_W-1:0] q);
		return $signed({p[UV_W-1], p}) - $signed({q[UV_W-1], q});
	endfunction

	function automatic logic [SUM_W-1:0] sadd(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s[SUM_W-1:0];
	endfunction

	// clamp to signed 48-bit range, then apply sign
	function automatic logic [SUM_W-1:0] fin_t(input logic [QUO_W-1:0] q, input logic neg);
		logic [QUO_W-1:0] lim;
		logic [QUO_W-1:0] m;
		lim = neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
		m   = (q > lim) ? lim : q;
		return neg ? SUM_W'(-m) : SUM_W'(m);
	endfunction

	state_t state_q;

	logic [PW-1:0] pos_mem [VERTEX_DEPTH];
	logic [SW-1:0] sum_mem [VERTEX_DEPTH];
	logic [PW-1:0] pm_rd_q;
	logic [SW-1:0] sm_rd_q;

	logic [IDX_W-1:0] ca_q, cb_q, cc_q, vi_q;
	logic [PW-1:0]    pa_q, pb_q;
	logic [3:0]       step_q;
	logic [1:0]       cn_q;

	logic signed [EW-1:0] e_q [6];
	logic signed [DW-1:0] du1_q, du2_q, dv1_q, dv2_q;
	logic signed [MW-1:0] prod_q;
	logic signed [AC-1:0] acc_q [4];
	logic [SUM_W-1:0]     t_q [3];
	logic [OUT_W-1:0]     res_q [3];
	logic                 clip_q, unused_q;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     tx_q, ty_q, tz_q;
	logic                 unused_o_q, clip_o_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic accept;
	logic pm_ren, sm_ren, pm_wen, sm_wen;
	logic [AW-1:0] pm_addr, sm_addr, pm_waddr, sm_waddr;
	logic [PW-1:0] pm_wdata;
	logic [SW-1:0] sm_wdata;

	logic signed [EW-1:0] op_a;
	logic signed [DW-1:0] op_b;
	logic signed [MW-1:0] prod_d;
	logic [3:0]           sm1;

	logic [IDX_W-1:0]     corner;
	logic signed [AC-1:0] det, num;
	logic [AC-1:0]        nmag;
	logic [DIV_W-1:0]     dmag;
	logic                 tneg, tovf;
	logic [SUM_W-1:0]     rsum;
	logic [SUM_W-1:0]     rmag;
	logic [CNT_W-1:0]     rcnt;
	logic [SUM_W-1:0]     nsx, nsy, nsz;
	logic [CNT_W-1:0]     ncnt;
	logic [OUT_W-1:0]     rval;
	logic                 rclip;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign det  = acc_q[0];
	assign num  = acc_q[2'(cn_q + 2'd1)];
	assign tneg = num[AC-1] ^ det[AC-1];
	assign nmag = num[AC-1] ? AC'(-num) : AC'(num);
	always_comb begin
		logic [AC-1:0] dfull;
		dfull = det[AC-1] ? AC'(-det) : AC'(det);
		dmag  = dfull[DIV_W-1:0];
	end
	assign tovf = {{DIV_W{1'b0}}, nmag} >= {{(AC-DIV_W){1'b0}}, dmag, {DIV_W{1'b0}}};

	always_comb begin
		unique case (cn_q)
			2'd0:    corner = ca_q;
			2'd1:    corner = cb_q;
			default: corner = cc_q;
		endcase
	end

	always_comb begin
		unique case (cn_q)
			2'd0:    rsum = sm_rd_q[SW-1 -: SUM_W];
			2'd1:    rsum = sm_rd_q[SW-1-SUM_W -: SUM_W];
			default: rsum = sm_rd_q[SW-1-2*SUM_W -: SUM_W];
		endcase
	end
	assign rcnt = sm_rd_q[CNT_W-1:0];
	assign rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : rsum;

	always_comb begin
		logic [QUO_W-1:0] q;
		q     = div_rsp.quo;
		rclip = 1'b0;
		if (rsum[SUM_W-1]) begin
			if (q > QUO_W'(64'h80000000)) begin
				rclip = 1'b1;
				rval  = 32'h80000000;
			end else begin
				rval = OUT_W'(-q);
			end
		end else begin
			if (q > QUO_W'(64'h7FFFFFFF)) begin
				rclip = 1'b1;
				rval  = 32'h7FFFFFFF;
			end else begin
				rval = q[OUT_W-1:0];
			end
		end
	end

	assign nsx  = sadd(sm_rd_q[SW-1 -: SUM_W], t_q[0]);
	assign nsy  = sadd(sm_rd_q[SW-1-SUM_W -: SUM_W], t_q[1]);
	assign nsz  = sadd(sm_rd_q[SW-1-2*SUM_W -: SUM_W], t_q[2]);
	assign ncnt = (rcnt == {CNT_W{1'b1}}) ? rcnt : rcnt + 1'b1;

	// shared multiplier operands
	always_comb begin
		unique case (step_q)
			4'd0:    op_a = EW'(du1_q);
			4'd1:    op_a = EW'(du2_q);
			4'd2:    op_a = e_q[0];
			4'd3:    op_a = e_q[1];
			4'd4:    op_a = e_q[2];
			4'd5:    op_a = e_q[3];
			4'd6:    op_a = e_q[4];
			default: op_a = e_q[5];
		endcase
		op_b = step_q[0] ? dv1_q : dv2_q;
	end
	assign prod_d = op_a * op_b;
	assign sm1    = step_q - 4'd1;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.rem_init = '0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		if (state_q == S_TDST) begin
			div_req.start    = !tovf;
			div_req.rem_init = DIV_W'(nmag >> DIV_W);
			div_req.dividend = {nmag[DIV_W-1:0], 14'b0};
			div_req.divisor  = dmag;
		end else if (state_q == S_RDST) begin
			div_req.start    = 1'b1;
			div_req.dividend = rmag;
			div_req.divisor  = DIV_W'(rcnt);
		end
	end

	mta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// memory port control
	always_comb begin
		pm_ren   = 1'b0;
		pm_addr  = to_addr(ca_q);
		sm_ren   = 1'b0;
		sm_addr  = to_addr(corner);
		pm_wen   = 1'b0;
		pm_waddr = to_addr(vertex_index);
		pm_wdata = {pos_x, pos_y, pos_z, tex_u, tex_v};
		sm_wen   = 1'b0;
		sm_waddr = to_addr(vertex_index);
		sm_wdata = '0;
		if (accept && kind == KIND_LOAD && in_range(vertex_index)) begin
			pm_wen = 1'b1;
			sm_wen = 1'b1;
		end
		unique case (state_q)
			S_TRA: pm_ren = 1'b1;
			S_TRB: begin
				pm_ren  = 1'b1;
				pm_addr = to_addr(cb_q);
			end
			S_TRC: begin
				pm_ren  = 1'b1;
				pm_addr = to_addr(cc_q);
			end
			S_TAR: sm_ren = 1'b1;
			S_TAW: begin
				sm_wen   = 1'b1;
				sm_waddr = to_addr(corner);
				sm_wdata = {nsx, nsy, nsz, ncnt};
			end
			S_RRD: begin
				sm_ren  = 1'b1;
				sm_addr = to_addr(vi_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_wen)
			pos_mem[pm_waddr] <= pm_wdata;
		if (pm_ren)
			pm_rd_q <= pos_mem[pm_addr];
	end

	always_ff @(posedge clk) begin
		if (sm_wen)
			sum_mem[sm_waddr] <= sm_wdata;
		if (sm_ren)
			sm_rd_q <= sum_mem[sm_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cn_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_TRI && in_range(corner_a) && in_range(corner_b)
								&& in_range(corner_c))
							state_q <= S_TRA;
						else if (kind == KIND_READ)
							state_q <= in_range(vertex_index) ? S_RRD : S_ROUT;
					end
				end
				S_TRA: state_q <= S_TRB;
				S_TRB: state_q <= S_TRC;
				S_TRC: state_q <= S_TDIF;
				S_TDIF: begin
					state_q <= S_TMUL;
					step_q  <= '0;
				end
				S_TMUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd8) begin
						cn_q    <= '0;
						state_q <= (det == '0) ? S_IDLE : S_TDST;
					end
				end
				S_TDST: begin
					if (!tovf)
						state_q <= S_TDWT;
					else if (cn_q == 2'd2) begin
						cn_q    <= '0;
						state_q <= S_TAR;
					end else
						cn_q <= cn_q + 2'd1;
				end
				S_TDWT: begin
					if (div_rsp.done) begin
						if (cn_q == 2'd2) begin
							cn_q    <= '0;
							state_q <= S_TAR;
						end else begin
							cn_q    <= cn_q + 2'd1;
							state_q <= S_TDST;
						end
					end
				end
				S_TAR: state_q <= S_TAW;
				S_TAW: begin
					if (cn_q == 2'd2)
						state_q <= S_IDLE;
					else begin
						cn_q    <= cn_q + 2'd1;
						state_q <= S_TAR;
					end
				end
				S_RRD: state_q <= S_RCHK;
				S_RCHK: begin
					cn_q    <= '0;
					state_q <= (rcnt == '0) ? S_ROUT : S_RDST;
				end
				S_RDST: state_q <= S_RDWT;
				S_RDWT: begin
					if (div_rsp.done) begin
						if (cn_q == 2'd2)
							state_q <= S_ROUT;
						else begin
							cn_q    <= cn_q + 2'd1;
							state_q <= S_RDST;
						end
					end
				end
				S_ROUT: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ca_q     <= corner_a;
			cb_q     <= corner_b;
			cc_q     <= corner_c;
			vi_q     <= vertex_index;
			res_q[0] <= '0;
			res_q[1] <= '0;
			res_q[2] <= '0;
			clip_q   <= 1'b0;
			unused_q <= 1'b1;
		end
		if (state_q == S_TRB)
			pa_q <= pm_rd_q;
		if (state_q == S_TRC)
			pb_q <= pm_rd_q;
		if (state_q == S_TDIF) begin
			e_q[0] <= dpos(pb_q[PW-1 -: POS_W], pa_q[PW-1 -: POS_W]);
			e_q[1] <= dpos(pm_rd_q[PW-1 -: POS_W], pa_q[PW-1 -: POS_W]);
			e_q[2] <= dpos(pb_q[PW-1-POS_W -: POS_W], pa_q[PW-1-POS_W -: POS_W]);
			e_q[3] <= dpos(pm_rd_q[PW-1-POS_W -: POS_W], pa_q[PW-1-POS_W -: POS_W]);
			e_q[4] <= dpos(pb_q[PW-1-2*POS_W -: POS_W], pa_q[PW-1-2*POS_W -: POS_W]);
			e_q[5] <= dpos(pm_rd_q[PW-1-2*POS_W -: POS_W], pa_q[PW-1-2*POS_W -: POS_W]);
			du1_q  <= duv(pb_q[2*UV_W-1 -: UV_W], pa_q[2*UV_W-1 -: UV_W]);
			du2_q  <= duv(pm_rd_q[2*UV_W-1 -: UV_W], pa_q[2*UV_W-1 -: UV_W]);
			dv1_q  <= duv(pb_q[UV_W-1:0], pa_q[UV_W-1:0]);
			dv2_q  <= duv(pm_rd_q[UV_W-1:0], pa_q[UV_W-1:0]);
		end
		if (state_q == S_TMUL) begin
			if (step_q != 4'd8)
				prod_q <= prod_d;
			if (step_q != 4'd0) begin
				if (!sm1[0])
					acc_q[sm1[2:1]] <= AC'(prod_q);
				else
					acc_q[sm1[2:1]] <= acc_q[sm1[2:1]] - AC'(prod_q);
			end
		end
		if (state_q == S_TDST && tovf)
			t_q[cn_q] <= fin_t({QUO_W{1'b1}}, tneg);
		if (state_q == S_TDWT && div_rsp.done)
			t_q[cn_q] <= fin_t(div_rsp.quo, tneg);
		if (state_q == S_RCHK && rcnt != '0)
			unused_q <= 1'b0;
		if (state_q == S_RDWT && div_rsp.done) begin
			res_q[cn_q] <= rval;
			if (rclip)
				clip_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_ROUT && (!out_valid_q || out_ready))
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROUT && (!out_valid_q || out_ready)) begin
			tx_q       <= res_q[0];
			ty_q       <= res_q[1];
			tz_q       <= res_q[2];
			unused_o_q <= unused_q;
			clip_o_q   <= clip_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign tangent_x     = tx_q;
	assign tangent_y     = ty_q;
	assign tangent_z     = tz_q;
	assign unused_vertex = unused_o_q;
	assign clipped       = clip_o_q;

endmodule

// ===== rtl/mta_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on mta_pkg.
module mta_div import mta_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CW = $clog2(QUO_W + 1);

	logic [DIV_W-1:0] r_q;
	logic [DIV_W-1:0] d_q;
	logic [QUO_W-1:0] q_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0] sh;
	logic [DIV_W:0] diff;
	logic           ge;

	assign sh   = {r_q, q_q[QUO_W-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.rem_init;
			q_q <= req.dividend;
			d_q <= req.divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
			q_q <= {q_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;

endmodule
